// ----- rtl/ibbe_pkg.sv -----
`default_nettype none
package ibbe_pkg;

  localparam int MAX_INSTANCES = 64;
  localparam int ADDR_W        = $clog2(MAX_INSTANCES);
  localparam int COUNT_W       = 7;
  localparam int ID_W          = 16;
  localparam int COORD_W       = 12;
  localparam int END_W         = COORD_W + 1;
  localparam int OUT_COORD_W   = 13;
  localparam int OUT_END_W     = 14;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(MAX_INSTANCES);
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(64);

  typedef struct packed {
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] left;
    logic [END_W-1:0]   bottom_end;
    logic [END_W-1:0]   right_end;
  } box_t;

  typedef struct packed {
    logic              valid;
    box_t              box;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    box_t              data;
  } wr_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FETCH,
    ST_SHOW
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/ibbe_table.sv -----
`default_nettype none
module ibbe_table (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         rd_en,
  input  wire  [ibbe_pkg::ADDR_W-1:0] rd_addr,
  input  wire  ibbe_pkg::wr_t         wr,
  input  wire                         clear_all,
  output ibbe_pkg::entry_t            entry
);

  ibbe_pkg::box_t                       mem [ibbe_pkg::MAX_INSTANCES];
  ibbe_pkg::box_t                       rd_data;
  ibbe_pkg::box_t                       fwd_data;
  logic                                 fwd;
  logic [ibbe_pkg::ADDR_W-1:0]          rd_addr_q;
  logic [ibbe_pkg::MAX_INSTANCES-1:0]   valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    fwd_data <= wr.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd       <= 1'b0;
      rd_addr_q <= '0;
      valid     <= '0;
    end else begin
      if (rd_en) begin
        rd_addr_q <= rd_addr;
        fwd       <= wr.en && (wr.addr == rd_addr);
      end
      if (clear_all) begin
        valid <= '0;
      end else if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
    end
  end

  // write landing on the entry being read is taken from the bypass
  always_comb begin
    entry.valid = valid[rd_addr_q];
    entry.box   = fwd ? fwd_data : rd_data;
  end

endmodule
`default_nettype wire

// ----- rtl/instance_bounding_box_extract.sv -----
// channel     direction  handshake                  payload
// pixel       in         pixel_valid / pixel_ready  instance_id pixel_row pixel_col frame_last
// box         out        box_valid / box_ready      box_index top_row left_col
//                                                   bottom_row_end right_col_end last_box
// config      in         instance_count_we          instance_count
//
// pixels are taken one per cycle while intake is open; each is a read-modify-write
// of the box table with a bypass for the same entry in successive cycles
// a word marked last stops intake while it is merged and, unless the instance count
// is zero, through readout; each box is a table read, then a present held through any
// output stall, and the table is cleared at the last box, or at once when the count is zero
// reset empties the table at once and sets the instance count to 64
`default_nettype none
module instance_bounding_box_extract (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  instance_count_we,
  input  wire  [ibbe_pkg::COUNT_W-1:0]         instance_count,
  input  wire                                  pixel_valid,
  output logic                                 pixel_ready,
  input  wire  [ibbe_pkg::ID_W-1:0]            instance_id,
  input  wire  [ibbe_pkg::COORD_W-1:0]         pixel_row,
  input  wire  [ibbe_pkg::COORD_W-1:0]         pixel_col,
  input  wire                                  frame_last,
  output logic                                 box_valid,
  input  wire                                  box_ready,
  output logic [ibbe_pkg::ADDR_W-1:0]          box_index,
  output logic signed [ibbe_pkg::OUT_COORD_W-1:0] top_row,
  output logic signed [ibbe_pkg::OUT_COORD_W-1:0] left_col,
  output logic signed [ibbe_pkg::OUT_END_W-1:0]   bottom_row_end,
  output logic signed [ibbe_pkg::OUT_END_W-1:0]   right_col_end,
  output logic                                 last_box
);

  logic [ibbe_pkg::COUNT_W-1:0] count_reg;
  logic [ibbe_pkg::COUNT_W-1:0] eff_count;
  ibbe_pkg::state_t             state;
  ibbe_pkg::state_t             state_next;
  logic [ibbe_pkg::ADDR_W-1:0]  k;
  logic [ibbe_pkg::ADDR_W-1:0]  k_next;

  logic                         p1_vld;
  logic                         p1_en;
  logic                         p1_last;
  logic [ibbe_pkg::ADDR_W-1:0]  p1_id;
  logic [ibbe_pkg::COORD_W-1:0] p1_row;
  logic [ibbe_pkg::COORD_W-1:0] p1_col;

  logic                         accept;
  logic                         rd_en;
  logic [ibbe_pkg::ADDR_W-1:0]  rd_addr;
  logic                         clear_all;
  ibbe_pkg::wr_t                wr;
  ibbe_pkg::entry_t             entry;
  logic [ibbe_pkg::END_W-1:0]   row_end;
  logic [ibbe_pkg::END_W-1:0]   col_end;

  assign eff_count = (count_reg > ibbe_pkg::COUNT_MAX) ? ibbe_pkg::COUNT_MAX : count_reg;
  assign accept    = pixel_valid && pixel_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg <= ibbe_pkg::COUNT_RESET;
    end else if (instance_count_we) begin
      count_reg <= instance_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld  <= 1'b0;
      p1_en   <= 1'b0;
      p1_last <= 1'b0;
    end else begin
      p1_vld  <= accept;
      p1_en   <= accept && (instance_id < ibbe_pkg::ID_W'(eff_count));
      p1_last <= accept && frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_id  <= instance_id[ibbe_pkg::ADDR_W-1:0];
      p1_row <= pixel_row;
      p1_col <= pixel_col;
    end
  end

  // merge stage
  always_comb begin
    row_end    = {1'b0, p1_row} + ibbe_pkg::END_W'(1);
    col_end    = {1'b0, p1_col} + ibbe_pkg::END_W'(1);
    wr.en      = p1_vld && p1_en;
    wr.addr    = p1_id;
    if (!entry.valid) begin
      wr.data.top        = p1_row;
      wr.data.left       = p1_col;
      wr.data.bottom_end = row_end;
      wr.data.right_end  = col_end;
    end else begin
      wr.data.top        = (p1_row < entry.box.top)  ? p1_row : entry.box.top;
      wr.data.left       = (p1_col < entry.box.left) ? p1_col : entry.box.left;
      wr.data.bottom_end = (row_end > entry.box.bottom_end) ? row_end : entry.box.bottom_end;
      wr.data.right_end  = (col_end > entry.box.right_end)  ? col_end : entry.box.right_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ibbe_pkg::ST_RUN;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next  = state;
    k_next      = k;
    pixel_ready = 1'b0;
    box_valid   = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = instance_id[ibbe_pkg::ADDR_W-1:0];
    clear_all   = 1'b0;
    last_box    = ({1'b0, k} + ibbe_pkg::COUNT_W'(1)) == eff_count;
    unique case (state)
      ibbe_pkg::ST_RUN: begin
        pixel_ready = !(p1_vld && p1_last);
        rd_en       = accept;
        if (p1_vld && p1_last) begin
          k_next = '0;
          if (eff_count != '0) begin
            state_next = ibbe_pkg::ST_FETCH;
          end else begin
            clear_all = 1'b1;
          end
        end
      end
      ibbe_pkg::ST_FETCH: begin
        rd_en      = 1'b1;
        rd_addr    = k;
        state_next = ibbe_pkg::ST_SHOW;
      end
      ibbe_pkg::ST_SHOW: begin
        box_valid = 1'b1;
        if (box_ready) begin
          if (last_box) begin
            clear_all  = 1'b1;
            state_next = ibbe_pkg::ST_RUN;
          end else begin
            k_next     = k + ibbe_pkg::ADDR_W'(1);
            state_next = ibbe_pkg::ST_FETCH;
          end
        end
      end
      default: begin
        state_next = ibbe_pkg::ST_RUN;
      end
    endcase
  end

  // absent boxes read as all ones
  always_comb begin
    box_index = k;
    if (entry.valid) begin
      top_row        = {1'b0, entry.box.top};
      left_col       = {1'b0, entry.box.left};
      bottom_row_end = {1'b0, entry.box.bottom_end};
      right_col_end  = {1'b0, entry.box.right_end};
    end else begin
      top_row        = '1;
      left_col       = '1;
      bottom_row_end = '1;
      right_col_end  = '1;
    end
  end

  ibbe_table u_table (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .wr        (wr),
    .clear_all (clear_all),
    .entry     (entry)
  );

endmodule
`default_nettype wire

// ----- bench/instance_bounding_box_extract_test.sv -----
`timescale 1ns / 100ps
module instance_bounding_box_extract_test;

  typedef struct packed {
    logic [ibbe_pkg::ADDR_W-1:0]             index;
    logic signed [ibbe_pkg::OUT_COORD_W-1:0] top;
    logic signed [ibbe_pkg::OUT_COORD_W-1:0] left;
    logic signed [ibbe_pkg::OUT_END_W-1:0]   bottom;
    logic signed [ibbe_pkg::OUT_END_W-1:0]   right;
    logic                                    closing;
  } box_word_t;

  typedef struct {
    bit                         seen;
    bit [ibbe_pkg::COORD_W-1:0] top;
    bit [ibbe_pkg::COORD_W-1:0] left;
    bit [ibbe_pkg::END_W-1:0]   bottom;
    bit [ibbe_pkg::END_W-1:0]   right;
  } label_box_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic instance_count_we = 1'b0;
  logic [ibbe_pkg::COUNT_W-1:0] instance_count = ibbe_pkg::COUNT_RESET;
  logic pixel_valid = 1'b0;
  logic pixel_ready;
  logic [ibbe_pkg::ID_W-1:0] instance_id = '0;
  logic [ibbe_pkg::COORD_W-1:0] pixel_row = '0;
  logic [ibbe_pkg::COORD_W-1:0] pixel_col = '0;
  logic frame_last = 1'b0;
  logic box_valid;
  logic box_ready = 1'b0;
  logic [ibbe_pkg::ADDR_W-1:0] box_index;
  logic signed [ibbe_pkg::OUT_COORD_W-1:0] top_row;
  logic signed [ibbe_pkg::OUT_COORD_W-1:0] left_col;
  logic signed [ibbe_pkg::OUT_END_W-1:0] bottom_row_end;
  logic signed [ibbe_pkg::OUT_END_W-1:0] right_col_end;
  logic last_box;

  label_box_t label_boxes[ibbe_pkg::MAX_INSTANCES];
  logic [ibbe_pkg::COUNT_W-1:0] tracked_count = ibbe_pkg::COUNT_RESET;
  box_word_t pending_boxes[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int live_count = ibbe_pkg::MAX_INSTANCES;
  bit hold_request = 1'b0;
  int hold_left = 0;

  instance_bounding_box_extract dut (
    .clk(clk),
    .rst(rst),
    .instance_count_we(instance_count_we),
    .instance_count(instance_count),
    .pixel_valid(pixel_valid),
    .pixel_ready(pixel_ready),
    .instance_id(instance_id),
    .pixel_row(pixel_row),
    .pixel_col(pixel_col),
    .frame_last(frame_last),
    .box_valid(box_valid),
    .box_ready(box_ready),
    .box_index(box_index),
    .top_row(top_row),
    .left_col(left_col),
    .bottom_row_end(bottom_row_end),
    .right_col_end(right_col_end),
    .last_box(last_box)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void clear_label_boxes();
    foreach (label_boxes[k]) begin
      label_boxes[k] = '{1'b0, '0, '0, '0, '0};
    end
  endfunction

  // fold one word into the box table; a word marked last also reads out and clears
  function automatic void fold_pixel(logic [ibbe_pkg::ID_W-1:0] id,
                                     logic [ibbe_pkg::COORD_W-1:0] row,
                                     logic [ibbe_pkg::COORD_W-1:0] col, logic is_last);
    int span;
    box_word_t word;
    span = (tracked_count > ibbe_pkg::MAX_INSTANCES) ? ibbe_pkg::MAX_INSTANCES
                                                     : int'(tracked_count);
    if (id < span) begin
      if (!label_boxes[id].seen) begin
        label_boxes[id] = '{1'b1, row, col, {1'b0, row} + 1'b1, {1'b0, col} + 1'b1};
      end else begin
        if (row < label_boxes[id].top) label_boxes[id].top = row;
        if (col < label_boxes[id].left) label_boxes[id].left = col;
        if ({1'b0, row} + 1'b1 > label_boxes[id].bottom)
          label_boxes[id].bottom = {1'b0, row} + 1'b1;
        if ({1'b0, col} + 1'b1 > label_boxes[id].right)
          label_boxes[id].right = {1'b0, col} + 1'b1;
      end
    end
    if (is_last) begin
      for (int k = 0; k < span; k++) begin
        word.index = k[ibbe_pkg::ADDR_W-1:0];
        if (label_boxes[k].seen) begin
          word.top = {1'b0, label_boxes[k].top};
          word.left = {1'b0, label_boxes[k].left};
          word.bottom = {1'b0, label_boxes[k].bottom};
          word.right = {1'b0, label_boxes[k].right};
        end else begin
          word.top = '1;
          word.left = '1;
          word.bottom = '1;
          word.right = '1;
        end
        word.closing = (k == span - 1);
        pending_boxes.push_back(word);
      end
      clear_label_boxes();
    end
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    box_word_t want;
    if (rst) begin
      clear_label_boxes();
      tracked_count = ibbe_pkg::COUNT_RESET;
    end else begin
      if (instance_count_we) tracked_count = instance_count;
      if (pixel_valid && pixel_ready) fold_pixel(instance_id, pixel_row, pixel_col, frame_last);
      if (box_valid && box_ready) begin
        if (pending_boxes.size() == 0) begin
          $error("box word with nothing pending: box_index %0d", box_index);
          mismatches++;
        end else begin
          want = pending_boxes.pop_front();
          check_field("box_index", int'(want.index), int'(box_index));
          check_field("top_row", int'(want.top), int'(top_row));
          check_field("left_col", int'(want.left), int'(left_col));
          check_field("bottom_row_end", int'(want.bottom), int'(bottom_row_end));
          check_field("right_col_end", int'(want.right), int'(right_col_end));
          check_field("last_box", int'(want.closing), int'(last_box));
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off when asked
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = 200;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      box_ready <= 1'b0;
      hold_left--;
    end else begin
      box_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_pixel(logic [ibbe_pkg::ID_W-1:0] id,
                            logic [ibbe_pkg::COORD_W-1:0] row,
                            logic [ibbe_pkg::COORD_W-1:0] col, logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(negedge clk);
    end
    pixel_valid <= 1'b1;
    instance_id <= id;
    pixel_row <= row;
    pixel_col <= col;
    frame_last <= is_last;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    pixel_valid <= 1'b0;
    while (pending_boxes.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic set_instance_count(int value);
    wait_drained();
    instance_count <= value[ibbe_pkg::COUNT_W-1:0];
    instance_count_we <= 1'b1;
    @(negedge clk);
    instance_count_we <= 1'b0;
    live_count = (value > ibbe_pkg::MAX_INSTANCES) ? ibbe_pkg::MAX_INSTANCES : value;
  endtask

  task automatic set_idling(int sender_pct, int receiver_pct);
    pixel_valid <= 1'b0;
    @(posedge clk);
    send_idle_pct = sender_pct;
    stall_pct = receiver_pct;
    @(negedge clk);
  endtask

  task automatic send_random_pixels(int count);
    logic [ibbe_pkg::ID_W-1:0] id;
    for (int n = 0; n < count; n++) begin
      if (live_count != 0 && $urandom_range(99) < 85)
        id = ibbe_pkg::ID_W'($urandom_range(live_count - 1));
      else id = ibbe_pkg::ID_W'($urandom);
      send_pixel(id, ibbe_pkg::COORD_W'($urandom), ibbe_pkg::COORD_W'($urandom),
                 (n == count - 1) || ($urandom_range(7) == 0));
    end
  endtask

  task automatic test_corner_pixels();
    set_idling(0, 0);
    set_instance_count(64);
    send_pixel(0, 0, 0, 1'b0);
    send_pixel(63, 4095, 4095, 1'b0);
    send_pixel(0, 4095, 0, 1'b0);
    send_pixel(0, 0, 4095, 1'b0);
    send_pixel(63, 0, 0, 1'b0);
    // same label back to back
    send_pixel(7, 100, 200, 1'b0);
    send_pixel(7, 50, 300, 1'b0);
    send_pixel(7, 150, 10, 1'b0);
    send_pixel(64, 1, 1, 1'b0);
    send_pixel(16'hffff, 2, 2, 1'b0);
    send_pixel(32, 2048, 2047, 1'b0);
    // out of range label still closes the frame
    send_pixel(1000, 5, 5, 1'b1);
    send_pixel(10, 1, 2, 1'b1);
    send_pixel(2, 10, 10, 1'b0);
    send_pixel(3, 11, 11, 1'b0);
    send_pixel(2, 9, 12, 1'b0);
    send_pixel(3, 12, 8, 1'b1);
  endtask

  task automatic test_count_settings();
    set_instance_count(1);
    send_pixel(0, 3, 4, 1'b0);
    send_pixel(1, 5, 5, 1'b0);
    send_pixel(0, 1, 9, 1'b1);
    set_instance_count(0);
    send_pixel(0, 3, 3, 1'b0);
    send_pixel(0, 4, 4, 1'b1);
    // above the table size acts as the full table
    set_instance_count(127);
    send_pixel(63, 7, 7, 1'b0);
    send_pixel(64, 8, 8, 1'b0);
    send_pixel(127, 1, 1, 1'b1);
  endtask

  task automatic test_random_traffic();
    set_idling(0, 0);
    set_instance_count(64);
    send_random_pixels(15);
    set_idling(74, 0);
    set_instance_count(5);
    send_random_pixels(15);
    set_idling(0, 74);
    set_instance_count(33);
    send_random_pixels(15);
    set_idling(28, 28);
    set_instance_count(127);
    send_random_pixels(15);
  endtask

  task automatic test_output_backpressure();
    set_idling(0, 0);
    set_instance_count(9);
    @(posedge clk);
    hold_request = 1'b1;
    @(negedge clk);
    send_random_pixels(4);
    send_random_pixels(6);
    send_random_pixels(5);
    // let every pending box out before going on
    wait_drained();
    send_random_pixels(8);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_corner_pixels();
    test_count_settings();
    test_random_traffic();
    test_output_backpressure();
    wait_drained();
    repeat (40) @(negedge clk);
    if (mismatches == 0) begin
      $display("instance_bounding_box_extract: match");
    end else begin
      $display("instance_bounding_box_extract: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("instance_bounding_box_extract: mismatch");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ibbe_pkg.sv
rtl/ibbe_table.sv
rtl/instance_bounding_box_extract.sv
bench/instance_bounding_box_extract_test.sv
